// ----- sv/rres_pkg.sv -----
// Package with types, constants and helpers for the round-robin epoch scheduler.
`timescale 1ns / 1ps
package rres_pkg;
  localparam int unsigned NumSlotsDefault  = 16;
  localparam int unsigned TimeWidthDefault = 16;
  localparam logic [7:0]  DefaultQuantum   = 8'd3;

  localparam logic [1:0] ModeTick = 2'd0;
  localparam logic [1:0] ModeIo   = 2'd1;
  localparam logic [1:0] ModeExit = 2'd2;

  typedef enum logic [1:0] {
    StReady   = 2'd0,
    StRunning = 2'd1,
    StSleep   = 2'd2,
    StDone    = 2'd3
  } slot_status_e;

  typedef enum logic [3:0] {
    FsmIdle   = 4'b0001,
    FsmSweep  = 4'b0010,
    FsmSearch = 4'b0100,
    FsmReport = 4'b1000
  } fsm_state_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] sleep_ticks;
    logic [3:0] exit_slot;
  } rres_in_t;

  typedef struct packed {
    logic        running_valid;
    logic [3:0]  running_slot;
    logic        refilled;
    logic        all_done;
    logic [15:0] tick_total;
    logic [15:0] idle_total;
    logic [15:0] switch_total;
    logic        exit_reported;
    logic [15:0] exit_wait;
    logic [15:0] exit_turnaround;
    logic [15:0] exit_response;
  } rres_out_t;

  // Command that the head cell of the ring applies to the slot that enters it.
  typedef struct packed {
    logic       tick;
    logic       charge;
    logic       refill;
    logic       sleep;
    logic       retire;
    logic       dispatch;
    logic [3:0] sleep_ticks;
    logic [7:0] quantum;
  } rres_cmd_t;
endpackage

// ----- sv/rres_cell.sv -----
// One slot cell of the scheduler ring, holding a slot's state and passing it on.
`timescale 1ns / 1ps
module rres_cell import rres_pkg::*; #(
  parameter int unsigned TimeWidth = TimeWidthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 shift_i,
  input  logic                 load_i,
  input  rres_cmd_t            cmd_i,
  input  logic [TimeWidth-1:0] tick_now_i,
  input  slot_status_e         st_i,
  input  logic [7:0]           q_i,
  input  logic [3:0]           sl_i,
  input  logic [TimeWidth-1:0] w_i,
  input  logic                 hr_i,
  input  logic [TimeWidth-1:0] fd_i,
  output slot_status_e         st_o,
  output logic [7:0]           q_o,
  output logic [3:0]           sl_o,
  output logic [TimeWidth-1:0] w_o,
  output logic                 hr_o,
  output logic [TimeWidth-1:0] fd_o
);
  localparam logic [TimeWidth-1:0] TimeMax = '1;

  slot_status_e         st_q, st_d;
  logic [7:0]           q_q, q_d;
  logic [3:0]           sl_q, sl_d;
  logic [TimeWidth-1:0] w_q, w_d, fd_q, fd_d;
  logic                 hr_q, hr_d;

  // The head cell applies the command to the slot that enters it; others only move data.
  always_comb begin
    st_d = st_i;
    q_d  = q_i;
    sl_d = sl_i;
    w_d  = w_i;
    hr_d = hr_i;
    fd_d = fd_i;
    if (load_i) begin
      if (cmd_i.tick) begin
        if (st_i == StSleep) begin
          if (sl_i <= 4'd1) begin
            sl_d = '0;
            st_d = StReady;
          end else begin
            sl_d = sl_i - 4'd1;
          end
        end else if (st_i == StReady && w_i != TimeMax) begin
          w_d = w_i + 1'b1;
        end
      end
      if (cmd_i.charge) begin
        if (q_i > 8'd1) begin
          q_d = q_i - 8'd1;
        end else begin
          q_d  = '0;
          st_d = StReady;
        end
      end
      if (cmd_i.refill && st_d != StDone) begin
        q_d = cmd_i.quantum;
      end
      if (cmd_i.sleep) begin
        st_d = StSleep;
        sl_d = cmd_i.sleep_ticks;
      end
      if (cmd_i.retire) begin
        st_d = StDone;
      end
      if (cmd_i.dispatch) begin
        st_d = StRunning;
        if (!hr_i) begin
          hr_d = 1'b1;
          fd_d = tick_now_i - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StReady;
      q_q  <= '0;
      sl_q <= '0;
      w_q  <= '0;
      hr_q <= 1'b0;
    end else if (shift_i) begin
      st_q <= st_d;
      q_q  <= q_d;
      sl_q <= sl_d;
      w_q  <= w_d;
      hr_q <= hr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      fd_q <= fd_d;
    end
  end

  assign st_o = st_q;
  assign q_o  = q_q;
  assign sl_o = sl_q;
  assign w_o  = w_q;
  assign hr_o = hr_q;
  assign fd_o = fd_q;
endmodule

// ----- sv/round_robin_epoch_scheduler.sv -----
// Top level of the round-robin epoch scheduler: control, counters and slot ring.
`timescale 1ns / 1ps
// The slot states sit in a ring of cells that rotates by one slot per cycle while an event
// is processed, so an event walks the ring once or twice. A tick while slots are live takes
// two passes: one applies the tick, finds whether a refill is due and notes the next ready
// slot after the search pointer; the other refills and dispatches that slot. Every other
// event, including a tick after all slots are done, takes one pass. busy is high from
// acceptance through the report state, and the result word is on out_o for one cycle,
// marked by out_valid_o. busy is already low in the result cycle, so the next event can be
// accepted at the edge that takes the result. The receiver cannot stall the result.
module round_robin_epoch_scheduler import rres_pkg::*; #(
  parameter int unsigned NumSlots  = NumSlotsDefault,
  parameter int unsigned TimeWidth = TimeWidthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  rres_in_t  in_i,
  output logic      out_valid_o,
  output rres_out_t out_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [7:0] cfg_data_i
);
  localparam int unsigned IdxW = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int unsigned CntW = $clog2(NumSlots + 1);
  localparam logic [TimeWidth-1:0] TimeMax = '1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumSlots - 1);

  fsm_state_e state_q, state_d;
  logic [7:0] quantum_q;
  rres_in_t   in_q;

  logic                 cur_valid_q;
  logic [IdxW-1:0]      cur_slot_q, ptr_q;
  logic [CntW-1:0]      live_q;
  logic [TimeWidth-1:0] tick_q, idle_q, switch_q;
  logic [IdxW-1:0]      pos_q;   // slot index now at the ring head
  logic [IdxW-1:0]      step_q;
  logic                 pass2_q, refill_q, any_q_q, found_q;
  logic                 refilled_q, rep_q;
  logic [TimeWidth-1:0] ew_q, er_q;
  logic                 rf_hi_q, rf_lo_q, nr_hi_q, nr_lo_q;
  logic [IdxW-1:0]      rf_hi_idx_q, rf_lo_idx_q, nr_hi_idx_q, nr_lo_idx_q;

  slot_status_e         st  [NumSlots];
  logic [7:0]           qv  [NumSlots];
  logic [3:0]           slv [NumSlots];
  logic [TimeWidth-1:0] wv  [NumSlots];
  logic                 hrv [NumSlots];
  logic [TimeWidth-1:0] fdv [NumSlots];

  rres_cmd_t cmd;
  logic      shift, head_match, idx_ok, cand;
  logic [IdxW-1:0] exit_idx;
  logic      expire_now, ready_now, nr_now, hi_now, pick_ok;
  logic [IdxW-1:0] pick_idx;

  assign busy        = (state_q != FsmIdle);
  assign cfg_ready_o = (state_q == FsmIdle);
  assign exit_idx    = IdxW'(in_q.exit_slot);
  assign idx_ok      = ({28'd0, in_q.exit_slot} < 32'(NumSlots));
  assign shift       = (state_q == FsmSweep) || (state_q == FsmSearch);
  assign head_match  = (pos_q == cur_slot_q) && cur_valid_q;

  // The sweep notes the first ready slot after the pointer and the first one at or before
  // it, both for the case of a refill and for the case without one.
  assign expire_now = cmd.charge && qv[0] <= 8'd1;
  assign ready_now  = (st[0] == StReady) || (st[0] == StSleep && slv[0] <= 4'd1) ||
                      expire_now;
  assign nr_now     = ready_now && !expire_now && qv[0] != 8'd0;
  assign hi_now     = (pos_q > ptr_q);
  assign pick_ok    = refill_q ? (rf_hi_q || rf_lo_q) : (nr_hi_q || nr_lo_q);
  assign pick_idx   = refill_q ? (rf_hi_q ? rf_hi_idx_q : rf_lo_idx_q) :
                                 (nr_hi_q ? nr_hi_idx_q : nr_lo_idx_q);
  assign cand       = pick_ok && (pos_q == pick_idx) && !found_q && !cur_valid_q;

  always_comb begin
    cmd = '0;
    cmd.sleep_ticks = in_q.sleep_ticks;
    cmd.quantum     = (quantum_q == 8'd0) ? DefaultQuantum : quantum_q;
    if (state_q == FsmSweep) begin
      unique case (in_q.mode)
        ModeTick: begin
          cmd.tick   = 1'b1;
          cmd.charge = head_match && st[0] == StRunning;
        end
        ModeIo:   cmd.sleep  = head_match;
        ModeExit: cmd.retire = idx_ok && pos_q == exit_idx && st[0] != StDone;
        default:  cmd = cmd;
      endcase
    end else if (state_q == FsmSearch) begin
      cmd.refill   = refill_q;
      cmd.dispatch = cand;
    end
  end

  for (genvar g = 0; g < NumSlots; g++) begin : g_ring
    localparam int unsigned Nx = (g + 1) % NumSlots;
    rres_cell #(.TimeWidth(TimeWidth)) u_cell (
      .clk_i, .rst_ni,
      .shift_i   (shift),
      .load_i    (Nx == 0),
      .cmd_i     (cmd),
      .tick_now_i(tick_q),
      .st_i(st[Nx]), .q_i(qv[Nx]), .sl_i(slv[Nx]), .w_i(wv[Nx]), .hr_i(hrv[Nx]),
      .fd_i(fdv[Nx]),
      .st_o(st[g]), .q_o(qv[g]), .sl_o(slv[g]), .w_o(wv[g]), .hr_o(hrv[g]),
      .fd_o(fdv[g])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FsmIdle:   if (start) state_d = FsmSweep;
      FsmSweep:  if (step_q == LastIdx) begin
        state_d = (in_q.mode == ModeTick && live_q != '0) ? FsmSearch : FsmReport;
      end
      FsmSearch: if (step_q == LastIdx) state_d = FsmReport;
      FsmReport: state_d = FsmIdle;
      default:   state_d = FsmIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FsmIdle;
      quantum_q   <= DefaultQuantum;
      in_q        <= '0;
      cur_valid_q <= 1'b0;
      cur_slot_q  <= '0;
      ptr_q       <= LastIdx;
      live_q      <= CntW'(NumSlots);
      tick_q      <= '0;
      idle_q      <= '0;
      switch_q    <= '0;
      pos_q       <= '0;
      step_q      <= '0;
      pass2_q     <= 1'b0;
      refill_q    <= 1'b0;
      any_q_q     <= 1'b0;
      found_q     <= 1'b0;
      refilled_q  <= 1'b0;
      rep_q       <= 1'b0;
      ew_q        <= '0;
      er_q        <= '0;
      rf_hi_q     <= 1'b0;
      rf_lo_q     <= 1'b0;
      nr_hi_q     <= 1'b0;
      nr_lo_q     <= 1'b0;
      rf_hi_idx_q <= '0;
      rf_lo_idx_q <= '0;
      nr_hi_idx_q <= '0;
      nr_lo_idx_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_o <= (state_q == FsmReport);
      if (cfg_valid_i && cfg_ready_o) quantum_q <= cfg_data_i;
      if (shift) begin
        pos_q  <= (pos_q == LastIdx) ? '0 : pos_q + 1'b1;
        step_q <= (step_q == LastIdx) ? '0 : step_q + 1'b1;
      end
      unique case (state_q)
        FsmIdle: begin
          rep_q   <= 1'b0;
          any_q_q <= 1'b0;
          found_q <= 1'b0;
          refilled_q <= 1'b0;
          rf_hi_q <= 1'b0;
          rf_lo_q <= 1'b0;
          nr_hi_q <= 1'b0;
          nr_lo_q <= 1'b0;
          if (start) begin
            in_q <= in_i;
            if (in_i.mode == ModeTick && live_q != '0 && tick_q != TimeMax) begin
              tick_q <= tick_q + 1'b1;
            end
          end
        end
        FsmSweep: begin
          if (ready_now) begin
            if (hi_now && !rf_hi_q) begin
              rf_hi_q     <= 1'b1;
              rf_hi_idx_q <= pos_q;
            end
            if (!hi_now && !rf_lo_q) begin
              rf_lo_q     <= 1'b1;
              rf_lo_idx_q <= pos_q;
            end
          end
          if (nr_now) begin
            if (hi_now && !nr_hi_q) begin
              nr_hi_q     <= 1'b1;
              nr_hi_idx_q <= pos_q;
            end
            if (!hi_now && !nr_lo_q) begin
              nr_lo_q     <= 1'b1;
              nr_lo_idx_q <= pos_q;
            end
          end
          if (in_q.mode == ModeTick && live_q != '0) begin
            if (cmd.charge && qv[0] <= 8'd1) begin
              cur_valid_q <= 1'b0;
              if (switch_q != TimeMax) switch_q <= switch_q + 1'b1;
            end
            if (st[0] != StDone && !(cmd.charge && qv[0] <= 8'd1) && qv[0] != 8'd0) begin
              any_q_q <= 1'b1;
            end
          end else if (cmd.sleep) begin
            cur_valid_q <= 1'b0;
            if (switch_q != TimeMax) switch_q <= switch_q + 1'b1;
          end else if (cmd.retire) begin
            live_q <= live_q - 1'b1;
            rep_q  <= 1'b1;
            ew_q   <= wv[0];
            er_q   <= hrv[0] ? fdv[0] : '0;
            if (head_match) begin
              cur_valid_q <= 1'b0;
              if (switch_q != TimeMax) switch_q <= switch_q + 1'b1;
            end
          end
          if (step_q == LastIdx) begin
            refill_q   <= !(any_q_q || (in_q.mode == ModeTick && st[0] != StDone &&
                           !(cmd.charge && qv[0] <= 8'd1) && qv[0] != 8'd0));
            refilled_q <= (in_q.mode == ModeTick && live_q != '0) &&
                          !(any_q_q || (st[0] != StDone &&
                           !(cmd.charge && qv[0] <= 8'd1) && qv[0] != 8'd0));
          end
        end
        FsmSearch: begin
          if (cand) begin
            found_q     <= 1'b1;
            cur_valid_q <= 1'b1;
            cur_slot_q  <= pos_q;
            ptr_q       <= pos_q;
          end
          if (step_q == LastIdx && !cur_valid_q && !found_q && !cand &&
              idle_q != TimeMax) begin
            idle_q <= idle_q + 1'b1;
          end
        end
        FsmReport: ;
        default: ;
      endcase
      pass2_q <= (state_q == FsmSearch);
    end
  end

  always_comb begin
    out_o = '0;
    out_o.running_valid = cur_valid_q;
    out_o.running_slot  = cur_valid_q ? 4'(cur_slot_q) : 4'd0;
    out_o.refilled      = refilled_q;
    out_o.all_done      = (live_q == '0);
    out_o.tick_total    = 16'(tick_q);
    out_o.idle_total    = 16'(idle_q);
    out_o.switch_total  = 16'(switch_q);
    out_o.exit_reported = rep_q;
    out_o.exit_wait       = rep_q ? 16'(ew_q) : 16'd0;
    out_o.exit_turnaround = rep_q ? 16'(tick_q) : 16'd0;
    out_o.exit_response   = rep_q ? 16'(er_q) : 16'd0;
  end

  // The ring head lines up with slot 0 whenever no event is being processed.
  a_ring_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FsmIdle |-> pos_q == '0 && step_q == '0)
    else $error("ring not home");
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o)
    else $error("double result");
  a_live_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= CntW'(NumSlots))
    else $error("live count overflow");
  a_pass_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pass2_q |-> $past(state_q) == FsmSearch)
    else $error("pass flag out of step");
  a_ptr_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FsmSearch && cand) |=> cur_valid_q && ptr_q == cur_slot_q)
    else $error("pointer lost");
endmodule
